// ===== design/qrs_pkg.sv =====
// qrs_pkg: shared types and constants for the quadratic root solver.
// No dependencies; imported by the top level, qrs_check and the bench.
`timescale 1ns / 1ps

package qrs_pkg;

   localparam int ROOT_WIDTH = 48;   // signed Q32.16 result roots
   localparam int TOL_WIDTH  = 8;    // zero tolerance, Q0.8 magnitude

   typedef enum logic [1:0] {
      COUNT_NONE = 2'd0,
      COUNT_ONE  = 2'd1,
      COUNT_TWO  = 2'd2,
      COUNT_ALL  = 2'd3
   } count_type;

   // Classification of one equation, carried down the pipeline.
   typedef struct packed {
      count_type count;
      logic      use_low;    // root_low is a real quotient
      logic      use_high;   // root_high is a real quotient
      logic      lin;        // linear case: -c/b
      logic      two;        // two distinct roots, sqrt needed
   } sel_type;

endpackage

// ===== design/quadratic_root_solver_top.sv =====
// quadratic_root_solver_top: streaming solver for a*x^2 + b*x + c = 0.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
`timescale 1ns / 1ps

// Solves one equation per beat, signed Q8.8 coefficients in, a solution
// count and two signed Q32.16 roots (truncated toward zero) out. A new
// equation is taken every cycle while the result side keeps up. A beat runs
// through capture, products, discriminant, classify, a bit-per-stage square
// root of the discriminant in Q18.32, dividends, the bit-per-stage dividers
// and the result register. The whole pipe moves as one: when the result
// register holds an untaken beat, every stage holds and req_ready drops, so
// nothing is lost or repeated. A coefficient whose magnitude is at or below
// zero_tolerance counts as zero; the discriminant is compared with
// zero_tolerance * 256. Write zero_tolerance only while the block is empty.
module quadratic_root_solver_top #(
   parameter int COEF_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COEF_WIDTH-1:0]          req_coef_a,
   input  logic signed [COEF_WIDTH-1:0]          req_coef_b,
   input  logic signed [COEF_WIDTH-1:0]          req_coef_c,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output qrs_pkg::count_type                    rsp_solution_count,
   output logic signed [qrs_pkg::ROOT_WIDTH-1:0] rsp_root_low,
   output logic signed [qrs_pkg::ROOT_WIDTH-1:0] rsp_root_high,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [qrs_pkg::TOL_WIDTH-1:0]         csr_zero_tolerance
);
   import qrs_pkg::*;

   localparam int W    = COEF_WIDTH;
   localparam int DW   = 2 * W + 2;          // discriminant, signed Q18.16
   localparam int RADW = DW + 16;            // radicand in Q18.32
   localparam int SW   = RADW / 2;           // sqrt D, Q9.16
   localparam int NW   = W + 19;             // signed dividend, Q.24
   localparam int DVW  = W + 1;              // signed divisor
   localparam int SELW = $bits(sel_type);
   localparam int TAGW = SELW + 3 * W;

   logic adv;   // whole pipe advances together

   // ---------------- configuration ----------------
   logic [TOL_WIDTH-1:0] tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_valid) begin
         tol_ff <= csr_zero_tolerance;
      end
   end

   // ---------------- S1: capture and zero tests ----------------
   logic [W-1:0] abs_a, abs_b, abs_c;
   logic signed [W-1:0] a1_ff, b1_ff, c1_ff;
   logic az1_ff, bz1_ff, cz1_ff, v1_ff;

   assign abs_a = req_coef_a[W-1] ? W'(-req_coef_a) : W'(req_coef_a);
   assign abs_b = req_coef_b[W-1] ? W'(-req_coef_b) : W'(req_coef_b);
   assign abs_c = req_coef_c[W-1] ? W'(-req_coef_c) : W'(req_coef_c);

   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff  <= req_coef_a;
         b1_ff  <= req_coef_b;
         c1_ff  <= req_coef_c;
         az1_ff <= {8'd0, abs_a} <= {{W{1'b0}}, tol_ff};
         bz1_ff <= {8'd0, abs_b} <= {{W{1'b0}}, tol_ff};
         cz1_ff <= {8'd0, abs_c} <= {{W{1'b0}}, tol_ff};
      end
   end

   // ---------------- S2: products ----------------
   logic signed [2*W-1:0] bb2_ff, ac2_ff;
   logic signed [W-1:0]   a2_ff, b2_ff, c2_ff;
   logic az2_ff, bz2_ff, cz2_ff, v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bb2_ff <= b1_ff * b1_ff;
         ac2_ff <= a1_ff * c1_ff;
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         c2_ff  <= c1_ff;
         az2_ff <= az1_ff;
         bz2_ff <= bz1_ff;
         cz2_ff <= cz1_ff;
      end
   end

   // ---------------- S3: discriminant ----------------
   logic signed [DW-1:0] d3_ff;
   logic signed [W-1:0]  a3_ff, b3_ff, c3_ff;
   logic az3_ff, bz3_ff, cz3_ff, v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d3_ff  <= DW'(bb2_ff) - (DW'(ac2_ff) <<< 2);
         a3_ff  <= a2_ff;
         b3_ff  <= b2_ff;
         c3_ff  <= c2_ff;
         az3_ff <= az2_ff;
         bz3_ff <= bz2_ff;
         cz3_ff <= cz2_ff;
      end
   end

   // ---------------- S4: classify, form radicand ----------------
   logic [DW-1:0] abs_d;
   logic          dz, dpos;
   sel_type       sel4_in;
   sel_type       sel4_ff;
   logic [RADW-1:0]     rad4_ff;
   logic signed [W-1:0] a4_ff, b4_ff, c4_ff;
   logic                v4_ff;

   assign abs_d = d3_ff[DW-1] ? DW'(-d3_ff) : DW'(d3_ff);
   assign dz    = {16'd0, abs_d} <= {{DW{1'b0}}, tol_ff, 8'd0};
   assign dpos  = !d3_ff[DW-1] && !dz;

   always_comb begin
      sel4_in = '{count: COUNT_NONE, use_low: 1'b0, use_high: 1'b0,
                  lin: 1'b0, two: 1'b0};
      if (az3_ff) begin
         if (bz3_ff) begin
            sel4_in.count = cz3_ff ? COUNT_ALL : COUNT_NONE;
         end else begin
            sel4_in.count   = COUNT_ONE;
            sel4_in.use_low = !cz3_ff;
            sel4_in.lin     = 1'b1;
         end
      end else if (dz) begin
         sel4_in.count   = COUNT_ONE;
         sel4_in.use_low = 1'b1;
      end else if (dpos) begin
         sel4_in.count    = COUNT_TWO;
         sel4_in.use_low  = 1'b1;
         sel4_in.use_high = 1'b1;
         sel4_in.two      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sel4_ff <= sel4_in;
         rad4_ff <= sel4_in.two ? {d3_ff, 16'd0} : '0;
         a4_ff   <= a3_ff;
         b4_ff   <= b3_ff;
         c4_ff   <= c3_ff;
      end
   end

   // ---------------- square root of D ----------------
   logic            sq_valid;
   logic [SW-1:0]   sq_root;
   logic [TAGW-1:0] sq_tag;

   qrs_sqrt #(
      .RAD_WIDTH (RADW),
      .TAG_WIDTH (TAGW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_rad    (rad4_ff),
      .in_tag    ({sel4_ff, a4_ff, b4_ff, c4_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // ---------------- S5: dividends and divisors ----------------
   sel_type              sel_s;
   logic signed [W-1:0]  a_s, b_s, c_s;
   logic signed [NW-1:0] nb, sw, num_lo_in, num_hi_in;
   logic signed [DVW-1:0] den_in;

   logic signed [NW-1:0]  num_lo_ff, num_hi_ff;
   logic signed [DVW-1:0] den_ff;
   sel_type               sel5_ff;
   logic                  v5_ff;

   assign sel_s = sel_type'(sq_tag[TAGW-1 -: SELW]);
   assign a_s   = sq_tag[3*W-1 -: W];
   assign b_s   = sq_tag[2*W-1 -: W];
   assign c_s   = sq_tag[W-1:0];

   always_comb begin
      nb = -(NW'(b_s) <<< 8);                 // -b in Q.16
      sw = signed'(NW'(sq_root));
      if (sel_s.lin) begin
         num_lo_in = -(NW'(c_s) <<< 16);
         num_hi_in = '0;
         den_in    = DVW'(b_s);
      end else begin
         num_lo_in = sel_s.two ? ((nb - sw) <<< 8) : (nb <<< 8);
         num_hi_in = (nb + sw) <<< 8;
         den_in    = DVW'(a_s) <<< 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_lo_ff <= num_lo_in;
         num_hi_ff <= num_hi_in;
         den_ff    <= den_in;
         sel5_ff   <= sel_s;
      end
   end

   // ---------------- dividers ----------------
   logic                 lo_valid, hi_valid;
   logic signed [NW-1:0] lo_quot, hi_quot;
   logic [SELW-1:0]      lo_tag;
   logic                 hi_use;

   qrs_div #(
      .NUM_WIDTH (NW),
      .DEN_WIDTH (DVW),
      .TAG_WIDTH (SELW)
   ) u_div_low (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v5_ff),
      .in_num    (num_lo_ff),
      .in_den    (den_ff),
      .in_tag    (sel5_ff),
      .out_valid (lo_valid),
      .out_quot  (lo_quot),
      .out_tag   (lo_tag)
   );

   qrs_div #(
      .NUM_WIDTH (NW),
      .DEN_WIDTH (DVW),
      .TAG_WIDTH (1)
   ) u_div_high (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v5_ff),
      .in_num    (num_hi_ff),
      .in_den    (den_ff),
      .in_tag    (sel5_ff.use_high),
      .out_valid (hi_valid),
      .out_quot  (hi_quot),
      .out_tag   (hi_use)
   );

   // ---------------- result register ----------------
   sel_type                      sel_o;
   logic                         rsp_valid_ff;
   count_type                    count_ff;
   logic signed [ROOT_WIDTH-1:0] root_low_ff, root_high_ff;

   assign sel_o = sel_type'(lo_tag);

   // hold every stage while an untaken beat sits in the result register
   assign adv = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= lo_valid && hi_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         count_ff     <= sel_o.count;
         root_low_ff  <= sel_o.use_low ? ROOT_WIDTH'(lo_quot) : '0;
         root_high_ff <= hi_use ? ROOT_WIDTH'(hi_quot) : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_solution_count = count_ff;
   assign rsp_root_low       = root_low_ff;
   assign rsp_root_high      = root_high_ff;

endmodule

// ===== design/qrs_sqrt.sv =====
// qrs_sqrt: fully pipelined floor square root, one result bit per stage.
// Depends on nothing but the stall enable from the top level.
`timescale 1ns / 1ps

module qrs_sqrt #(
   parameter int RAD_WIDTH = 50,
   parameter int TAG_WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [RAD_WIDTH-1:0]     in_rad,
   input  logic [TAG_WIDTH-1:0]     in_tag,
   output logic                     out_valid,
   output logic [RAD_WIDTH/2-1:0]   out_root,
   output logic [TAG_WIDTH-1:0]     out_tag
);

   localparam int N  = RAD_WIDTH / 2;
   localparam int RW = N + 2;

   logic [RW-1:0]        rem_ff   [N];
   logic [N-1:0]         root_ff  [N];
   logic [RAD_WIDTH-1:0] rad_ff   [N];
   logic [TAG_WIDTH-1:0] tag_ff   [N];
   logic                 valid_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [RW-1:0]        prev_rem;
      logic [N-1:0]         prev_root;
      logic [RAD_WIDTH-1:0] prev_rad;
      logic [TAG_WIDTH-1:0] prev_tag;
      logic                 prev_valid;
      logic [RW-1:0]        cur;
      logic [RW-1:0]        trial;
      logic [RW-1:0]        rem_in;
      logic [N-1:0]         root_in;

      if (i == 0) begin : g_first
         assign prev_rem   = '0;
         assign prev_root  = '0;
         assign prev_rad   = in_rad;
         assign prev_tag   = in_tag;
         assign prev_valid = in_valid;
      end else begin : g_next
         assign prev_rem   = rem_ff[i-1];
         assign prev_root  = root_ff[i-1];
         assign prev_rad   = rad_ff[i-1];
         assign prev_tag   = tag_ff[i-1];
         assign prev_valid = valid_ff[i-1];
      end

      always_comb begin
         cur   = {prev_rem[RW-3:0], prev_rad[RAD_WIDTH-1 -: 2]};
         trial = {prev_root, 2'b01};
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {prev_root[N-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {prev_root[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (adv) begin
            valid_ff[i] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            rad_ff[i]  <= {prev_rad[RAD_WIDTH-3:0], 2'b00};
            tag_ff[i]  <= prev_tag;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_tag   = tag_ff[N-1];

endmodule

// ===== design/qrs_div.sv =====
// qrs_div: pipelined signed divider, truncating toward zero, one quotient
// bit per stage. Depends only on the stall enable from the top level.
`timescale 1ns / 1ps

module qrs_div #(
   parameter int NUM_WIDTH = 35,
   parameter int DEN_WIDTH = 17,
   parameter int TAG_WIDTH = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic signed [NUM_WIDTH-1:0] in_num,
   input  logic signed [DEN_WIDTH-1:0] in_den,
   input  logic [TAG_WIDTH-1:0]        in_tag,
   output logic                        out_valid,
   output logic signed [NUM_WIDTH-1:0] out_quot,
   output logic [TAG_WIDTH-1:0]        out_tag
);

   // entry stage: magnitudes and result sign
   logic [NUM_WIDTH-1:0] nm_ff;
   logic [DEN_WIDTH-1:0] dm_ff;
   logic                 neg_ff;
   logic [TAG_WIDTH-1:0] etag_ff;
   logic                 evalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         evalid_ff <= 1'b0;
      end else if (adv) begin
         evalid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nm_ff   <= in_num[NUM_WIDTH-1] ? NUM_WIDTH'(-in_num) : NUM_WIDTH'(in_num);
         dm_ff   <= in_den[DEN_WIDTH-1] ? DEN_WIDTH'(-in_den) : DEN_WIDTH'(in_den);
         neg_ff  <= in_num[NUM_WIDTH-1] ^ in_den[DEN_WIDTH-1];
         etag_ff <= in_tag;
      end
   end

   // restoring steps: numerator bits shift out the top, quotient bits in
   logic [DEN_WIDTH-1:0] rem_ff   [NUM_WIDTH];
   logic [NUM_WIDTH-1:0] nq_ff    [NUM_WIDTH];
   logic [DEN_WIDTH-1:0] sdm_ff   [NUM_WIDTH];
   logic                 sneg_ff  [NUM_WIDTH];
   logic [TAG_WIDTH-1:0] stag_ff  [NUM_WIDTH];
   logic                 svalid_ff[NUM_WIDTH];

   for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_step
      logic [DEN_WIDTH-1:0] prev_rem;
      logic [NUM_WIDTH-1:0] prev_nq;
      logic [DEN_WIDTH-1:0] prev_dm;
      logic                 prev_neg;
      logic [TAG_WIDTH-1:0] prev_tag;
      logic                 prev_valid;
      logic [DEN_WIDTH:0]   cur;
      logic [DEN_WIDTH-1:0] rem_in;
      logic                 qbit;

      if (i == 0) begin : g_first
         assign prev_rem   = '0;
         assign prev_nq    = nm_ff;
         assign prev_dm    = dm_ff;
         assign prev_neg   = neg_ff;
         assign prev_tag   = etag_ff;
         assign prev_valid = evalid_ff;
      end else begin : g_next
         assign prev_rem   = rem_ff[i-1];
         assign prev_nq    = nq_ff[i-1];
         assign prev_dm    = sdm_ff[i-1];
         assign prev_neg   = sneg_ff[i-1];
         assign prev_tag   = stag_ff[i-1];
         assign prev_valid = svalid_ff[i-1];
      end

      always_comb begin
         cur = {prev_rem, prev_nq[NUM_WIDTH-1]};
         if (cur >= {1'b0, prev_dm}) begin
            rem_in = DEN_WIDTH'(cur - {1'b0, prev_dm});
            qbit   = 1'b1;
         end else begin
            rem_in = DEN_WIDTH'(cur);
            qbit   = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            svalid_ff[i] <= 1'b0;
         end else if (adv) begin
            svalid_ff[i] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i]  <= rem_in;
            nq_ff[i]   <= {prev_nq[NUM_WIDTH-2:0], qbit};
            sdm_ff[i]  <= prev_dm;
            sneg_ff[i] <= prev_neg;
            stag_ff[i] <= prev_tag;
         end
      end
   end

   // exit stage: restore the sign
   logic signed [NUM_WIDTH-1:0] quot_ff;
   logic [TAG_WIDTH-1:0]        otag_ff;
   logic                        ovalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (adv) begin
         ovalid_ff <= svalid_ff[NUM_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quot_ff <= sneg_ff[NUM_WIDTH-1] ? -nq_ff[NUM_WIDTH-1] : nq_ff[NUM_WIDTH-1];
         otag_ff <= stag_ff[NUM_WIDTH-1];
      end
   end

   assign out_valid = ovalid_ff;
   assign out_quot  = quot_ff;
   assign out_tag   = otag_ff;

endmodule

// ===== design/qrs_check.sv =====
// qrs_check: port-level checks on the result channel of the solver.
// Depends on qrs_pkg; bound to quadratic_root_solver_top below.
`timescale 1ns / 1ps

module qrs_check (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input qrs_pkg::count_type                    rsp_solution_count,
   input logic signed [qrs_pkg::ROOT_WIDTH-1:0] rsp_root_low,
   input logic signed [qrs_pkg::ROOT_WIDTH-1:0] rsp_root_high
);
   import qrs_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_solution_count)
         && $stable(rsp_root_low) && $stable(rsp_root_high))
      else $error("result beat changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_solution_count == COUNT_NONE || rsp_solution_count == COUNT_ALL)
         |-> rsp_root_low == '0 && rsp_root_high == '0)
      else $error("roots set without a finite solution");

   a_one_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_solution_count == COUNT_ONE |-> rsp_root_high == '0)
      else $error("second root set for a single solution");

endmodule

bind quadratic_root_solver_top qrs_check u_qrs_check (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_solution_count (rsp_solution_count),
   .rsp_root_low       (rsp_root_low),
   .rsp_root_high      (rsp_root_high)
);

// ===== tb/quadratic_root_solver_top_tb.sv =====
// quadratic_root_solver_top_tb: self-checking bench for the quadratic root solver.
// Depends on qrs_pkg and quadratic_root_solver_top; predicts every result in place.
`timescale 1ns / 1ps

module quadratic_root_solver_top_tb;
   import qrs_pkg::*;

   localparam int CW = 16;
   localparam int LATENCY = 4 + (CW + 9) + 1 + (CW + 21) + 1;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      count_type        count;
      logic signed [47:0] low;
      logic signed [47:0] high;
   } solution_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [CW-1:0] req_coef_a = '0, req_coef_b = '0, req_coef_c = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   count_type rsp_solution_count;
   logic signed [47:0] rsp_root_low, rsp_root_high;
   logic csr_valid = 0;
   logic csr_ready;
   logic [TOL_WIDTH-1:0] csr_zero_tolerance = '0;

   // Predictor copy of the tolerance register.
   logic [7:0] tolerance = 0;
   solution_type pending_solutions[$];
   int mismatches = 0;
   longint cycles = 0;
   int stall_mode = 0;

   quadratic_root_solver_top #(.COEF_WIDTH(CW)) dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Integer floor root of d * 2^16, i.e. sqrt(D) in Q16.16.
   function automatic longint unsigned disc_root(longint unsigned d);
      longint unsigned rem, root, trial, pair;
      rem = 0;
      root = 0;
      for (int i = 31; i >= -8; i--) begin
         pair = (i >= 0) ? ((d >> (2 * i)) & 3) : 0;
         rem = (rem << 2) | pair;
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem -= trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic longint magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic solution_type solve_equation(logic signed [CW-1:0] ca,
                                                   logic signed [CW-1:0] cb,
                                                   logic signed [CW-1:0] cc);
      longint a, b, c, d, den, nb, s, r1, r2;
      bit az, bz, cz;
      solution_type sol;
      a = ca;
      b = cb;
      c = cc;
      az = magnitude(a) <= tolerance;
      bz = magnitude(b) <= tolerance;
      cz = magnitude(c) <= tolerance;
      r1 = 0;
      r2 = 0;
      sol.count = COUNT_NONE;
      if (az) begin
         if (bz) begin
            sol.count = cz ? COUNT_ALL : COUNT_NONE;
         end else begin
            sol.count = COUNT_ONE;
            if (!cz) r1 = (-c * 65536) / b;
         end
      end else begin
         d = b * b - 4 * a * c;
         den = 2 * a;
         nb = -b * 256;
         if (magnitude(d) <= longint'(tolerance) * 256) begin
            sol.count = COUNT_ONE;
            r1 = (nb * 256) / den;
         end else if (d > 0) begin
            s = longint'(disc_root(d));
            sol.count = COUNT_TWO;
            r1 = ((nb - s) * 256) / den;
            r2 = ((nb + s) * 256) / den;
         end
      end
      sol.low = r1[47:0];
      sol.high = r2[47:0];
      return sol;
   endfunction

   // Receiver: stall on a pattern picked by the current phase, check each beat.
   always @(posedge clock) begin
      solution_type want;
      if (!reset) begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= (cycles % 7) < 3;
         endcase
         if (rsp_valid && rsp_ready) begin
            if (pending_solutions.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat");
            end else begin
               want = pending_solutions.pop_front();
               if (rsp_solution_count !== want.count || rsp_root_low !== want.low
                   || rsp_root_high !== want.high) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %0d %0d %0d got %0d %0d %0d", want.count,
                              want.low, want.high, rsp_solution_count, rsp_root_low,
                              rsp_root_high);
               end
            end
         end
      end
   end

   // Send one equation beat; predict on acceptance. Valid stays up for the
   // next beat; whoever idles the sender drops it.
   task automatic send_equation(logic signed [CW-1:0] ca, logic signed [CW-1:0] cb,
                                logic signed [CW-1:0] cc);
      req_valid <= 1'b1;
      req_coef_a <= ca;
      req_coef_b <= cb;
      req_coef_c <= cc;
      do @(posedge clock); while (!req_ready);
      pending_solutions.push_back(solve_equation(ca, cb, cc));
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_solutions.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [7:0] value);
      drain_pipe();
      csr_valid <= 1'b1;
      csr_zero_tolerance <= value;
      do @(posedge clock); while (!csr_ready);
      tolerance = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed_cases();
      logic signed [CW-1:0] ext[4];
      ext = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
      send_equation(16'sh0000, 16'sh0000, 16'sh0000);   // every real
      send_equation(16'sh0000, 16'sh0000, 16'sh0100);   // no root
      send_equation(16'sh0000, 16'sh0200, 16'sh0000);   // linear, zero root
      send_equation(16'sh0000, 16'sh0200, 16'sh0300);   // linear
      send_equation(16'sh0100, 16'shFE00, 16'sh0100);   // double root
      send_equation(16'sh0100, 16'sh0000, 16'sh0100);   // negative discriminant
      send_equation(16'sh0100, 16'sh0000, 16'shFF00);   // two roots
      send_equation(16'shFF00, 16'sh0000, 16'sh0100);   // negative a, reversed order
      foreach (ext[i]) send_equation(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
      send_equation(16'sh8000, 16'sh8000, 16'sh7FFF);
      send_equation(16'sh7FFF, 16'sh8000, 16'sh8000);
      send_equation(16'sh0001, 16'sh7FFF, 16'sh0001);
   endtask

   task automatic test_random_equations(int count);
      int burst;
      logic signed [CW-1:0] ca, cb, cc;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && count > 0; i++, count--) begin
            // Mix narrow coefficients (near tolerance) with full-range ones.
            case ($urandom_range(0, 3))
               0: begin
                  ca = CW'($urandom);
                  cb = CW'($urandom);
                  cc = CW'($urandom);
               end
               1: begin
                  ca = CW'($signed(8'($urandom)));
                  cb = CW'($signed(12'($urandom)));
                  cc = CW'($signed(8'($urandom)));
               end
               2: begin
                  ca = $urandom_range(0, 1) ? CW'($signed(6'($urandom))) : CW'($urandom);
                  cb = $urandom_range(0, 1) ? CW'($signed(6'($urandom))) : CW'($urandom);
                  cc = $urandom_range(0, 1) ? CW'($signed(6'($urandom))) : CW'($urandom);
               end
               default: begin
                  // a*x^2 - 2*r*a*x + r*r*a style: near-zero discriminant
                  ca = CW'($signed(6'($urandom)) * 256);
                  cb = CW'(-2 * ca);
                  cc = CW'(ca + $signed(4'($urandom)));
               end
            endcase
            send_equation(ca, cb, cc);
         end
         if ($urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      stall_mode = 1;
      test_random_equations(150);
      // Hold the sender until every result is back.
      drain_pipe();
      write_tolerance(8'hFF);
      test_directed_cases();
      test_random_equations(150);
      write_tolerance(8'd1);
      stall_mode = 2;
      test_random_equations(150);
      write_tolerance(8'd40);
      stall_mode = 0;
      test_random_equations(150);
      write_tolerance(8'd0);
      test_random_equations(50);
      drain_pipe();
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/qrs_pkg.sv
design/qrs_sqrt.sv
design/qrs_div.sv
design/quadratic_root_solver_top.sv
design/qrs_check.sv
tb/quadratic_root_solver_top_tb.sv
